>>> sv/nad_pkg.sv
// Package for the activation unit with derivative: widths, mode codes and the
// elaboration-time builders of the sigmoid and tanh tables. No dependencies.
package nad_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int DER_W           = 12;
  localparam int MODE_W          = 2;
  localparam int TAB_W           = 31;
  localparam int TAB_Q           = 30;
  localparam int SIG_SPAN_LOG    = 4;
  localparam int TANH_SPAN_LOG   = 3;
  localparam int TAB_MAX         = 1024;
  localparam int TIX_W           = $clog2(TAB_MAX + 1);
  localparam int TAB_ENTRIES_DEF = 256;
  localparam int FRAC_BITS_DEF   = 11;

  typedef enum logic [MODE_W-1:0] {
    MODE_RELU  = 2'd0,
    MODE_SIG   = 2'd1,
    MODE_TANH  = 2'd2,
    MODE_IDENT = 2'd3
  } mode_t;

  typedef logic [TAB_MAX:0][TAB_W-1:0] tab_arr_t;

  // Shift-subtract quotient, evaluated at elaboration only.
  function automatic logic [63:0] nad_udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series for exp(-16/n) in Q32, each term truncated in turn.
  function automatic logic [63:0] nad_exp_step(int unsigned n);
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] acc;
    h    = nad_udiv64(64'd16 << 32, 64'(n));
    term = 64'd1 << 32;
    acc  = 64'd1 << 32;
    for (int k = 1; k < 48; k++) begin
      if (term != 64'd0) begin
        term = nad_udiv64((term * h) >> 32, 64'(k));
        if (k[0]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

  // Q30 sigmoid (tanh_sel low) or tanh (tanh_sel high) table, n+1 points.
  function automatic tab_arr_t nad_build_tab(int unsigned n, bit tanh_sel);
    tab_arr_t    tab;
    logic [63:0] c;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] val;
    tab = '0;
    c   = nad_exp_step(n);
    e   = 64'd1 << 32;
    for (int k = 0; k <= TAB_MAX; k++) begin
      if (k <= int'(n)) begin
        den = (64'd1 << 32) + e;
        if (tanh_sel) begin
          val = nad_udiv64((((64'd1 << 32) - e) << TAB_Q) + (den >> 1), den);
        end else begin
          val = nad_udiv64((64'd1 << 62) + (den >> 1), den);
        end
        tab[k] = TAB_W'(val);
        e      = (e * c + (64'd1 << 31)) >> 32;
      end
    end
    return tab;
  endfunction

endpackage

>>> sv/nad_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module nad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/neural_activation_with_derivative.sv
// Activation unit: ReLU, sigmoid, tanh or identity with derivative, Q4.11.
// Uses nad_pkg and nad_ram (interpolation pairs of both tables, one row each).
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | start / busy         | in_sample_in, in_last_in
//   out     | out_valid (strobe)   | out_activation_out, out_derivative_out,
//           |                      | out_last_out
//   cfg     | cfg_we               | cfg_wdata (mode)
//
// One beat per cycle while busy is low; each result is registered through the pipeline stages and the output register.
// The rate is set by the table RAM: one read returns both interpolation points.
// After reset busy stays high while the table RAM loads.
// The receiver cannot stall: out_valid is a one-cycle strobe.
module neural_activation_with_derivative #(
  parameter int TABLE_ENTRIES = nad_pkg::TAB_ENTRIES_DEF,
  parameter int FRAC_BITS     = nad_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [nad_pkg::MODE_W-1:0]          cfg_wdata,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [nad_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                in_last_in,
  output logic                                out_valid,
  output logic signed [nad_pkg::SAMPLE_W-1:0] out_activation_out,
  output logic [nad_pkg::DER_W-1:0]           out_derivative_out,
  output logic                                out_last_out
);

  import nad_pkg::*;

  localparam int AW      = $clog2(TABLE_ENTRIES);
  localparam int MAG_W   = SAMPLE_W + 1;
  localparam int PW      = MAG_W + $clog2(TABLE_ENTRIES + 1);
  localparam int FR_W    = FRAC_BITS + SIG_SPAN_LOG;
  localparam int WT_W    = FR_W + 1;
  localparam int PROD_W  = TAB_W + WT_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int ONE_W   = FRAC_BITS + 1;
  localparam int SQ_W    = 2 * ONE_W;
  localparam int RAM_W   = 4 * TAB_W;
  localparam int SIG_SH  = TAB_Q + SIG_SPAN_LOG;
  localparam int TANH_SH = TAB_Q + TANH_SPAN_LOG;

  localparam logic [ONE_W-1:0] ONE      = ONE_W'(1) << FRAC_BITS;
  localparam logic [SQ_W-1:0]  SQ_HALF  = SQ_W'(1) << (FRAC_BITS - 1);
  localparam logic [NUM_W-1:0] RND_SIG  = NUM_W'(1) << (SIG_SH - 1);
  localparam logic [NUM_W-1:0] RND_TANH = NUM_W'(1) << (TANH_SH - 1);

  localparam tab_arr_t SIG_TAB  = nad_build_tab(TABLE_ENTRIES, 1'b0);
  localparam tab_arr_t TANH_TAB = nad_build_tab(TABLE_ENTRIES, 1'b1);

  // configuration and table load
  mode_t             mode_r;
  logic              filling_r;
  logic [AW-1:0]     fill_cnt_r;
  logic [TIX_W-1:0]  fill_ix;
  logic [RAM_W-1:0]  fill_data;
  logic [RAM_W-1:0]  ram_rdata;

  // stage 0
  logic              accept;
  logic [SAMPLE_W-1:0] raw0;
  logic              neg0;
  logic [MAG_W-1:0]  mag0;
  logic [PW-1:0]     p0;
  logic [PW-1:0]     idx0;
  logic [FR_W-1:0]   fr0;
  logic              sat0;

  // stage 1
  logic              v1_r;
  logic [SAMPLE_W-1:0] raw1_r;
  logic              neg1_r;
  logic [FR_W-1:0]   fr1_r;
  logic              sat1_r;
  logic              last1_r;
  logic [TAB_W-1:0]  lo1;
  logic [TAB_W-1:0]  hi1;
  logic [WT_W-1:0]   span1;
  logic [WT_W-1:0]   wlo1;

  // stage 2
  logic              v2_r;
  logic [SAMPLE_W-1:0] raw2_r;
  logic              neg2_r;
  logic              sat2_r;
  logic              last2_r;
  logic [PROD_W-1:0] plo2_r;
  logic [PROD_W-1:0] phi2_r;
  logic [NUM_W-1:0]  num2;
  logic [NUM_W-1:0]  r2;
  logic [ONE_W-1:0]  m2;
  logic [ONE_W-1:0]  a2;
  logic              pos2;
  logic [SAMPLE_W-1:0] act2;
  logic [ONE_W-1:0]  opx2;
  logic [ONE_W-1:0]  opy2;

  // stage 3
  logic              v3_r;
  logic [SAMPLE_W-1:0] act3_r;
  logic              pos3_r;
  logic              last3_r;
  logic [ONE_W-1:0]  opx3_r;
  logic [ONE_W-1:0]  opy3_r;

  // stage 4
  logic              v4_r;
  logic [SAMPLE_W-1:0] act4_r;
  logic              pos4_r;
  logic              last4_r;
  logic [SQ_W-1:0]   sq4_r;
  logic [ONE_W-1:0]  rnd4;
  logic [ONE_W-1:0]  der4;

  // output
  logic              out_valid_r;
  logic [SAMPLE_W-1:0] out_act_r;
  logic [DER_W-1:0]  out_der_r;
  logic              out_last_r;

  assign fill_ix   = TIX_W'(fill_cnt_r);
  assign fill_data = {SIG_TAB[fill_ix], SIG_TAB[fill_ix + TIX_W'(1)],
                      TANH_TAB[fill_ix], TANH_TAB[fill_ix + TIX_W'(1)]};

  assign accept = start && !filling_r;

  always_comb begin
    raw0 = in_sample_in;
    neg0 = raw0[SAMPLE_W-1];
    mag0 = neg0 ? (MAG_W'(1) << SAMPLE_W) - MAG_W'(raw0) : MAG_W'(raw0);
    p0   = PW'(mag0) * PW'(TABLE_ENTRIES);
    if (mode_r == MODE_TANH) begin
      idx0 = p0 >> (FRAC_BITS + TANH_SPAN_LOG);
      fr0  = FR_W'(p0 & ((PW'(1) << (FRAC_BITS + TANH_SPAN_LOG)) - PW'(1)));
    end else begin
      idx0 = p0 >> (FRAC_BITS + SIG_SPAN_LOG);
      fr0  = FR_W'(p0 & ((PW'(1) << (FRAC_BITS + SIG_SPAN_LOG)) - PW'(1)));
    end
    sat0 = idx0 >= PW'(TABLE_ENTRIES);
  end

  nad_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_tab_ram (
    .clk   (clk),
    .we    (filling_r),
    .waddr (fill_cnt_r),
    .wdata (fill_data),
    .re    (accept),
    .raddr (idx0[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (mode_r == MODE_TANH) begin
      lo1   = ram_rdata[2*TAB_W-1:TAB_W];
      hi1   = ram_rdata[TAB_W-1:0];
      span1 = WT_W'(1) << (FRAC_BITS + TANH_SPAN_LOG);
    end else begin
      lo1   = ram_rdata[4*TAB_W-1:3*TAB_W];
      hi1   = ram_rdata[3*TAB_W-1:2*TAB_W];
      span1 = WT_W'(1) << (FRAC_BITS + SIG_SPAN_LOG);
    end
    wlo1 = span1 - WT_W'(fr1_r);
  end

  always_comb begin
    num2 = NUM_W'(plo2_r) + NUM_W'(phi2_r);
    if (mode_r == MODE_TANH) begin
      r2 = (num2 + RND_TANH) >> TANH_SH;
    end else begin
      r2 = (num2 + RND_SIG) >> SIG_SH;
    end
    m2   = (sat2_r || (r2 > NUM_W'(ONE))) ? ONE : ONE_W'(r2);
    a2   = neg2_r ? ONE - m2 : m2;
    pos2 = !neg2_r && (raw2_r != '0);
    opx2 = m2;
    opy2 = m2;
    unique case (mode_r)
      MODE_RELU: begin
        act2 = pos2 ? raw2_r : '0;
      end
      MODE_SIG: begin
        act2 = SAMPLE_W'(a2);
        opx2 = a2;
        opy2 = ONE - a2;
      end
      MODE_TANH: begin
        act2 = neg2_r ? SAMPLE_W'(0) - SAMPLE_W'(m2) : SAMPLE_W'(m2);
      end
      MODE_IDENT: begin
        act2 = raw2_r;
      end
    endcase
  end

  always_comb begin
    rnd4 = ONE_W'((sq4_r + SQ_HALF) >> FRAC_BITS);
    unique case (mode_r)
      MODE_RELU:  der4 = pos4_r ? ONE : '0;
      MODE_SIG:   der4 = rnd4;
      MODE_TANH:  der4 = ONE - rnd4;
      MODE_IDENT: der4 = ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RELU;
      filling_r   <= 1'b1;
      fill_cnt_r  <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= mode_t'(cfg_wdata);
      end
      if (filling_r) begin
        fill_cnt_r <= fill_cnt_r + AW'(1);
        if (fill_cnt_r == AW'(TABLE_ENTRIES - 1)) begin
          filling_r <= 1'b0;
        end
      end
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    raw1_r  <= raw0;
    neg1_r  <= neg0;
    fr1_r   <= fr0;
    sat1_r  <= sat0;
    last1_r <= in_last_in;

    raw2_r  <= raw1_r;
    neg2_r  <= neg1_r;
    sat2_r  <= sat1_r;
    last2_r <= last1_r;
    plo2_r  <= PROD_W'(lo1) * PROD_W'(wlo1);
    phi2_r  <= PROD_W'(hi1) * PROD_W'(fr1_r);

    act3_r  <= act2;
    pos3_r  <= pos2;
    last3_r <= last2_r;
    opx3_r  <= opx2;
    opy3_r  <= opy2;

    act4_r  <= act3_r;
    pos4_r  <= pos3_r;
    last4_r <= last3_r;
    sq4_r   <= SQ_W'(opx3_r) * SQ_W'(opy3_r);

    out_act_r  <= act4_r;
    out_der_r  <= DER_W'(der4);
    out_last_r <= last4_r;
  end

  assign busy               = filling_r;
  assign out_valid          = out_valid_r;
  assign out_activation_out = out_act_r;
  assign out_derivative_out = out_der_r;
  assign out_last_out       = out_last_r;

endmodule

>>> verif/tb.sv
// Testbench for neural_activation_with_derivative: a bit-exact activation and
// derivative predictor checks every result beat in order, over all modes.
// Depends on nad_pkg and the RTL of the block; reads no files.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nad_pkg::*;

  localparam int N_TAB        = TAB_ENTRIES_DEF;
  localparam int FRAC         = FRAC_BITS_DEF;
  localparam longint ONE_FX   = 64'd1 << FRAC;
  localparam int LATENCY      = 5;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] act;
    logic [DER_W-1:0]    der;
    logic                last;
  } act_beat_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [MODE_W-1:0]          cfg_wdata;
  logic                       start;
  logic                       busy;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       in_last_in;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_activation_out;
  logic [DER_W-1:0]           out_derivative_out;
  logic                       out_last_out;

  logic [63:0] sig_q30  [0:N_TAB];
  logic [63:0] tanh_q30 [0:N_TAB];
  mode_t       cur_mode;
  act_beat_t   pending_results[$];
  act_beat_t   want;
  int          err_cnt;
  int          cycle_cnt;
  int          idle_pct;

  neural_activation_with_derivative DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .start              (start),
    .busy               (busy),
    .in_sample_in       (in_sample_in),
    .in_last_in         (in_last_in),
    .out_valid          (out_valid),
    .out_activation_out (out_activation_out),
    .out_derivative_out (out_derivative_out),
    .out_last_out       (out_last_out)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void build_act_tables();
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] step;
    logic [63:0] e;
    logic [63:0] den;
    h    = (64'd16 << 32) / 64'(N_TAB);
    term = 64'd1 << 32;
    step = 64'd1 << 32;
    for (int k = 1; k < 48 && term != 64'd0; k++) begin
      term = ((term * h) >> 32) / 64'(k);
      if (k % 2 == 1) begin
        step = step - term;
      end else begin
        step = step + term;
      end
    end
    e = 64'd1 << 32;
    for (int k = 0; k <= N_TAB; k++) begin
      den         = (64'd1 << 32) + e;
      sig_q30[k]  = ((64'd1 << 62) + den / 2) / den;
      tanh_q30[k] = ((((64'd1 << 32) - e) << TAB_Q) + den / 2) / den;
      e           = (e * step + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic logic [63:0] interp_q(bit tanh_sel, logic [63:0] mag);
    logic [63:0] d;
    logic [63:0] p;
    logic [63:0] idx;
    logic [63:0] fr;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] r;
    d   = 64'd1 << ((tanh_sel ? TANH_SPAN_LOG : SIG_SPAN_LOG) + FRAC);
    p   = mag * 64'(N_TAB);
    idx = p / d;
    fr  = p % d;
    if (idx >= 64'(N_TAB)) begin
      return ONE_FX;
    end
    if (tanh_sel) begin
      num = tanh_q30[idx] * (d - fr) + tanh_q30[idx + 1] * fr;
    end else begin
      num = sig_q30[idx] * (d - fr) + sig_q30[idx + 1] * fr;
    end
    den = d << (TAB_Q - FRAC);
    r   = (num + den / 2) / den;
    return (r > ONE_FX) ? ONE_FX : r;
  endfunction

  function automatic act_beat_t predict_activation(logic [15:0] raw, logic lst, mode_t m);
    act_beat_t   res;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] act;
    logic [63:0] der;
    logic [63:0] v;
    neg = raw[15];
    mag = neg ? (64'h10000 - 64'(raw)) : 64'(raw);
    act = '0;
    der = '0;
    case (m)
      MODE_RELU: begin
        if (!neg && raw != 16'd0) begin
          act = 64'(raw);
          der = ONE_FX;
        end
      end
      MODE_SIG: begin
        v   = interp_q(1'b0, mag);
        act = neg ? (ONE_FX - v) : v;
        der = (act * (ONE_FX - act) + ONE_FX / 2) >> FRAC;
      end
      MODE_TANH: begin
        v   = interp_q(1'b1, mag);
        act = neg ? (64'h10000 - v) : v;
        der = ONE_FX - ((v * v + ONE_FX / 2) >> FRAC);
      end
      default: begin
        act = 64'(raw);
        der = ONE_FX;
      end
    endcase
    res.act  = act[SAMPLE_W-1:0];
    res.der  = der[DER_W-1:0];
    res.last = lst;
    return res;
  endfunction

  function automatic logic [15:0] pick_sample();
    int unsigned sel;
    logic [15:0] v;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3: v = 16'($urandom);
      4, 5, 6:    v = 16'($urandom_range(12288));
      7:          v = 16'(16384 - 64 + $urandom_range(128));
      8: begin
        case ($urandom_range(4))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 16'h0000;
          3:       v = 16'h0001;
          default: v = 16'hFFFF;
        endcase
      end
      default:    v = 16'($urandom_range(63));
    endcase
    if (sel >= 4 && sel != 8 && $urandom_range(1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic note_mismatch(string what, longint want_v, longint got_v);
    if (err_cnt < MAX_REPORTS) begin
      $display("mismatch %s: expected %0d, got %0d", what, want_v, got_v);
    end
    err_cnt++;
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected beat, activation", 0, longint'(out_activation_out));
      end else begin
        want = pending_results.pop_front();
        if (out_activation_out !== want.act) begin
          note_mismatch("activation", longint'($signed(want.act)),
                        longint'(out_activation_out));
        end
        if (out_derivative_out !== want.der) begin
          note_mismatch("derivative", longint'(want.der), longint'(out_derivative_out));
        end
        if (out_last_out !== want.last) begin
          note_mismatch("last", longint'(want.last), longint'(out_last_out));
        end
      end
    end
  end

  // Entered and left just after a falling edge; start stays high for back-to-back beats.
  task automatic send_sample(logic [15:0] smp, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start        = 1'b1;
    in_sample_in = smp;
    in_last_in   = lst;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_activation(smp, lst, cur_mode));
    @(negedge clk);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_mode(mode_t m);
    drain_results();
    repeat (LATENCY + 2) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = m;
    cur_mode  = m;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic test_reset_mode();
    idle_pct = 0;
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
  endtask

  task automatic test_mode_extremes();
    set_mode(MODE_SIG);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd100, 1'b1);
    set_mode(MODE_TANH);
    send_sample(16'h0000, 1'b0);
    send_sample(16'd16384, 1'b1);
    send_sample(-16'sd16384, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b1);
    set_mode(MODE_IDENT);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(-16'sd5, 1'b0);
  endtask

  task automatic test_random_stream();
    int pcts [3] = '{0, 80, 7};
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = pcts[ph];
      for (int blk = 0; blk < 4; blk++) begin
        set_mode(mode_t'((blk + ph) % 4));
        repeat (125) send_sample(pick_sample(), $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic test_drain_pause();
    idle_pct = 7;
    set_mode(mode_t'($urandom_range(3)));
    repeat (40) send_sample(pick_sample(), $urandom_range(7) == 0);
    drain_results();
    repeat (40) send_sample(pick_sample(), $urandom_range(7) == 0);
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = MODE_RELU;
    start        = 1'b0;
    in_sample_in = '0;
    in_last_in   = 1'b0;
    cur_mode     = MODE_RELU;
    err_cnt      = 0;
    cycle_cnt    = 0;
    idle_pct     = 0;
    build_act_tables();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_mode();
    test_mode_extremes();
    test_random_stream();
    test_drain_pause();

    drain_results();
    repeat (LATENCY * 4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> neural_activation_with_derivative.f
sv/nad_pkg.sv
sv/nad_ram.sv
sv/neural_activation_with_derivative.sv
verif/tb.sv
